[design/assert_macros.svh]
// assertion macros used by the checker file
// needs clk_i and rst_ni visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[design/aedm_pkg.sv]
// shared types and constants of the audio echo delay mixer
// no dependencies
package aedm_pkg;

  // field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned DELAY_W   = 14;
  localparam int unsigned DIV_W     = 15;
  localparam int unsigned SEEN_W    = 14;
  localparam int unsigned CFG_W     = 15;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned STEP_W    = $clog2(SAMPLE_W);

  // ring depth default
  localparam int unsigned MAX_DELAY_DEF = 8192;

  // register reset values
  localparam logic [DELAY_W-1:0] DELAY_RESET   = 14'd8000;
  localparam logic [DIV_W-1:0]   DIVISOR_RESET = 15'd4;
  localparam logic [SEEN_W-1:0]  SEEN_MAX      = 14'h3fff;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_DIVISOR = 1'b1;

  // input mode codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  // control state
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  // control from the sequencer to the serial datapath
  typedef struct packed {
    logic load;
    logic shift;
  } serial_ctrl_t;

endpackage

[design/aedm_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module aedm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/aedm_serial.sv]
// bit-serial datapath: restoring signed divider and lsb-first mix adder
// depends on aedm_pkg
module aedm_serial (
  input  logic                                   clk_i,
  input  aedm_pkg::serial_ctrl_t                 ctrl_i,
  input  logic signed [aedm_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic        [aedm_pkg::SAMPLE_W-1:0]   echo_i,
  input  logic        [aedm_pkg::DIV_W-1:0]      divisor_i,
  output logic        [aedm_pkg::SAMPLE_W-1:0]   scaled_o,
  output logic        [aedm_pkg::SAMPLE_W-1:0]   sum_o
);
  import aedm_pkg::*;

  logic [SAMPLE_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0]    rem_q, rem_d;
  logic                neg_q;
  logic [SAMPLE_W-1:0] a_q, b_q, sum_q;
  logic                carry_q, carry_d;
  logic [SAMPLE_W-1:0] magnitude;
  logic [SAMPLE_W-1:0] trial;
  logic [SAMPLE_W-1:0] trial_diff;
  logic                fits;
  logic                sum_bit;

  // magnitude of the incoming sample, 0x8000 stays as unsigned 32768
  assign magnitude = sample_i[SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;

  // one restoring division step: bring down the next dividend bit
  always_comb begin
    trial      = {rem_q, dvd_q[SAMPLE_W-1]};
    trial_diff = trial - {1'b0, divisor_i};
    fits       = (trial >= {1'b0, divisor_i});
    rem_d      = fits ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
    dvd_d      = {dvd_q[SAMPLE_W-2:0], fits};
  end

  // one full-adder step on the low bits of echo and sample
  always_comb begin
    sum_bit = a_q[0] ^ b_q[0] ^ carry_q;
    carry_d = (a_q[0] & b_q[0]) | (a_q[0] & carry_q) | (b_q[0] & carry_q);
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      dvd_q   <= magnitude;
      rem_q   <= '0;
      neg_q   <= sample_i[SAMPLE_W-1];
      a_q     <= echo_i;
      b_q     <= sample_i;
      carry_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      dvd_q   <= dvd_d;
      rem_q   <= rem_d;
      a_q     <= {1'b0, a_q[SAMPLE_W-1:1]};
      b_q     <= {1'b0, b_q[SAMPLE_W-1:1]};
      carry_q <= carry_d;
      sum_q   <= {sum_bit, sum_q[SAMPLE_W-1:1]};
    end
  end

  // quotient truncates toward zero: negate the magnitude quotient
  assign scaled_o = neg_q ? (~dvd_q + 1'b1) : dvd_q;
  assign sum_o    = sum_q;

endmodule

[design/audio_echo_delay_mixer_top.sv]
// audio echo delay mixer: feedforward comb echo on signed 16-bit samples
// sequence: accept in idle, load, a 16-step serial division, then done until the result is taken
// a new transaction is not accepted until the previous result is in the output register
// reset: asynchronous, clears control state, then a clearing pass over every ring
// address zeroes the ring with in_ready_o low; config writes are taken throughout
// depends on aedm_pkg, aedm_ram and aedm_serial
module audio_echo_delay_mixer_top #(
  parameter int unsigned MAX_DELAY = aedm_pkg::MAX_DELAY_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [aedm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [aedm_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 mode_i,
  input  logic signed [aedm_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [aedm_pkg::SAMPLE_W-1:0] out_sample_o
);
  import aedm_pkg::*;

  localparam int unsigned IDX_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int unsigned CMP_W = 17;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_DELAY - 1);
  localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_DELAY);

  state_e state_q, state_d;

  logic [DELAY_W-1:0]  delay_q;
  logic [DIV_W-1:0]    divisor_q;
  logic [IDX_W-1:0]    ring_idx_q;
  logic [IDX_W-1:0]    clr_addr_q;
  logic [SEEN_W-1:0]   seen_q;
  logic [STEP_W-1:0]   step_q;
  logic                mode_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;

  logic                in_fire;
  logic                finish;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [SAMPLE_W-1:0] ram_rdata;
  serial_ctrl_t        ser_ctrl;
  logic [SAMPLE_W-1:0] scaled;
  logic [SAMPLE_W-1:0] mix_sum;
  logic [DIV_W-1:0]    div_eff;
  logic [CMP_W-1:0]    active_delay;
  logic [CMP_W-1:0]    idx_next;
  logic [SAMPLE_W-1:0] result;

  assign in_fire = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q   <= DELAY_RESET;
      divisor_q <= DIVISOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DELAY_LENGTH:   delay_q   <= cfg_data_i[DELAY_W-1:0];
        CFG_VOLUME_DIVISOR: divisor_q <= cfg_data_i[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // effective delay and divisor after clamping
  always_comb begin
    active_delay = {{(CMP_W-DELAY_W){1'b0}}, delay_q};
    if (active_delay == '0) begin
      active_delay = CMP_W'(1);
    end
    if (active_delay > MAX_CMP) begin
      active_delay = MAX_CMP;
    end
    div_eff = (divisor_q == '0) ? DIV_W'(1) : divisor_q;
  end

  // ring index advance with wrap
  always_comb begin
    idx_next = {{(CMP_W-IDX_W){1'b0}}, ring_idx_q} + CMP_W'(1);
    if (idx_next >= active_delay || idx_next >= MAX_CMP) begin
      idx_next = '0;
    end
  end

  // result selection
  always_comb begin
    if (mode_q == MODE_FLUSH) begin
      result = ram_rdata;
    end else if ({{(CMP_W-SEEN_W){1'b0}}, seen_q} < active_delay) begin
      result = sample_q;
    end else begin
      result = mix_sum;
    end
  end

  // sequencer: next state and controls
  always_comb begin
    state_d       = state_q;
    ser_ctrl      = '0;
    finish        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ring_idx_q;
    ram_wdata     = scaled;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
        if (clr_addr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ser_ctrl.load = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        ser_ctrl.shift = 1'b1;
        if (step_q == STEP_W'(SAMPLE_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          finish  = 1'b1;
          ram_we  = (mode_q == MODE_SAMPLE);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // clearing sweep address and serial step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      step_q     <= '0;
    end else begin
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (ser_ctrl.load) begin
        step_q <= '0;
      end else if (ser_ctrl.shift) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // ring index and sample count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_idx_q <= '0;
      seen_q     <= '0;
    end else if (finish) begin
      ring_idx_q <= idx_next[IDX_W-1:0];
      if (mode_q == MODE_SAMPLE && seen_q != SEEN_MAX) begin
        seen_q <= seen_q + 1'b1;
      end
    end
  end

  // captured input transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q   <= mode_i;
      sample_q <= in_sample_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_sample_q <= result;
    end
  end

  // echo ring
  aedm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DELAY)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (ring_idx_q),
    .rdata_o (ram_rdata)
  );

  // serial divider and mix adder
  aedm_serial u_serial (
    .clk_i     (clk_i),
    .ctrl_i    (ser_ctrl),
    .sample_i  (sample_q),
    .echo_i    (ram_rdata),
    .divisor_i (div_eff),
    .scaled_o  (scaled),
    .sum_o     (mix_sum)
  );

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;

endmodule

[design/aedm_checker.sv]
// port-level checker for the audio echo delay mixer, bound to the top level
// depends on assert_macros.svh and aedm_pkg
`include "assert_macros.svh"

module aedm_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 cfg_we_i,
  input logic [aedm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input logic [aedm_pkg::CFG_W-1:0]           cfg_data_i,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 mode_i,
  input logic signed [aedm_pkg::SAMPLE_W-1:0] in_sample_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [aedm_pkg::SAMPLE_W-1:0] out_sample_o
);

  // a pending result stays offered
  `ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  // a stalled result keeps its value
  `ASSERT_CLK(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_sample_o), "result changed")

  // one transaction at a time: ready drops after an accept
  `ASSERT_CLK(a_one_at_a_time, in_valid_i && in_ready_o |=> !in_ready_o, "second accept")

  // a result never appears the cycle after an accept
  `ASSERT_CLK(a_no_instant, in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o, "early result")

endmodule

bind audio_echo_delay_mixer_top aedm_checker u_checker (.*);
